// ----- rtl/p2i_pkg.sv -----
// Shared types, mode codes and constants for the PCM16 converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package p2i_pkg;

    typedef enum logic [2:0] {
        MODE_PCM16   = 3'd0,
        MODE_FLOAT32 = 3'd1,
        MODE_INT32   = 3'd2,
        MODE_INT24   = 3'd3,
        MODE_UINT8   = 3'd4
    } mode_t;

    localparam logic [0:0] REG_MODE  = 1'b0;
    localparam logic [0:0] REG_LIMIT = 1'b1;

    localparam logic [31:0] BYTES_PER_SAMPLE = 32'd2;
    localparam logic [14:0] FULL_SCALE       = 15'd32767;

    // Converter output item (combinational): the converted sample before tracking.
    typedef struct packed {
        logic [15:0] pcm;
        logic [15:0] mag;
    } conv_t;

endpackage
`default_nettype wire

// ----- rtl/p2i_convert.sv -----
// Sample format conversion to signed 16-bit PCM (combinational).
// Depends on p2i_pkg.
`timescale 1ns / 1ps
`default_nettype none
module p2i_convert
    import p2i_pkg::*;
(
    input  wire logic [2:0]  mode,
    input  wire logic [31:0] bits_in,
    output conv_t            conv
);
    logic [7:0]  expo;
    logic [23:0] mant;
    logic [38:0] prod;
    logic [8:0]  shamt;
    logic [38:0] ipart;
    logic [38:0] rmask;
    logic [38:0] rem;
    logic [38:0] half;
    logic [38:0] prnd;
    logic [4:0]  plen;
    logic [38:0] pmask;
    logic [38:0] pkeep;
    logic [38:0] pdrop;
    logic [38:0] phalf;
    logic [38:0] pq;
    logic [16:0] mag_f;
    logic [15:0] fpcm;
    logic [15:0] pcm;

    // Form the exact product of |v| and 32767 (24x15), then round it twice.
    always_comb begin
        expo  = bits_in[30:23];
        mant  = {1'b1, bits_in[22:0]};
        prod  = '0;
        shamt = '0;
        pmask = '0;
        pkeep = '0;
        pdrop = '0;
        phalf = '0;
        pq    = '0;
        plen  = '0;
        ipart = '0;
        rmask = '0;
        rem   = '0;
        half  = '0;
        prnd  = '0;
        mag_f = '0;
        if (expo == 8'hFF && bits_in[22:0] != 23'd0) begin
            mag_f = '0;
        end else if (expo >= 8'd127) begin
            mag_f = 17'd32767;
        end else if (expo == 8'd0) begin
            mag_f = '0;
        end else begin
            prod = 39'(mant) * 39'(FULL_SCALE);
            // round product to 24 significant bits (binary32)
            plen = prod[38] ? 5'd15 : 5'd14;
            pmask = (39'd1 << plen) - 39'd1;
            pdrop = prod & pmask;
            phalf = 39'd1 << (plen - 5'd1);
            pkeep = prod & ~pmask;
            if (pdrop > phalf || (pdrop == phalf && prod[plen])) begin
                pq = pkeep + (39'd1 << plen);
            end else begin
                pq = pkeep;
            end
            // value = pq * 2^(expo-150); integer rounding nearest-even
            shamt = 9'd150 - {1'b0, expo};
            if (shamt > 9'd39) begin
                mag_f = '0;
            end else begin
                ipart = pq >> shamt[5:0];
                rmask = (39'd1 << shamt[5:0]) - 39'd1;
                rem   = pq & rmask;
                half  = 39'd1 << (shamt[5:0] - 6'd1);
                if (rem > half || (rem == half && ipart[0])) begin
                    prnd = ipart + 39'd1;
                end else begin
                    prnd = ipart;
                end
                mag_f = prnd[16:0];
            end
        end
        fpcm = bits_in[31] ? 16'(17'd0 - mag_f) : mag_f[15:0];
    end

    // Select per mode.
    always_comb begin
        unique case (mode)
            MODE_FLOAT32: pcm = fpcm;
            MODE_INT32:   pcm = bits_in[31:16];
            MODE_INT24:   pcm = bits_in[23:8];
            MODE_UINT8:   pcm = {~bits_in[7], bits_in[6:0], 8'd0};
            default:      pcm = bits_in[15:0];
        endcase
        conv.pcm = pcm;
        conv.mag = pcm[15] ? 16'(17'h10000 - {1'b0, pcm}) : pcm;
    end
endmodule
`default_nettype wire

// ----- rtl/pcm_to_int16_converter_peak_core.sv -----
// PCM16 converter with peak and byte-limit tracking.
// Accepted samples pass the input reg, then the result reg, which sets valid.
// One item per cycle while m_ready is high; tracking updates in result stage.
// Reset: synchronous active-low aresetn clears counters, peak, error and valids,
// mode to passthrough and byte limit to all ones.
// Depends on p2i_pkg and p2i_convert.
`timescale 1ns / 1ps
`default_nettype none
module pcm_to_int16_converter_peak_core
    import p2i_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_sample_bits,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_pcm_sample,
    output logic             m_sample_written,
    output logic [15:0]      m_peak_level,
    output logic             m_peak_seen,
    output logic             m_limit_error,
    output logic [31:0]      m_bytes_total
);
    logic [2:0]  mode_reg;
    logic [31:0] limit_reg;
    logic        in_valid_reg;
    logic [31:0] in_bits_reg;
    conv_t       conv;
    logic [31:0] count_reg;
    logic [15:0] peak_reg;
    logic        seen_reg;
    logic        err_reg;
    logic        out_valid_reg;
    logic [15:0] out_pcm_reg;
    logic        out_wr_reg;
    logic        adv;
    logic        fits;

    assign cfg_ready = 1'b1;
    assign adv       = !out_valid_reg || m_ready;
    assign s_ready   = adv || !in_valid_reg;

    p2i_convert u_convert (
        .mode    (mode_reg),
        .bits_in (in_bits_reg),
        .conv    (conv)
    );

    assign fits = ({1'b0, count_reg} + 33'd2) <= {1'b0, limit_reg};

    // Hold config, advance input and result stages, update tracking.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_PCM16;
            limit_reg     <= '1;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            peak_reg      <= '0;
            seen_reg      <= 1'b0;
            err_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_MODE) begin
                    mode_reg <= cfg_data[2:0];
                end else begin
                    limit_reg <= cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                in_bits_reg <= s_sample_bits;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    if (!err_reg && fits) begin
                        out_pcm_reg <= conv.pcm;
                        out_wr_reg  <= 1'b1;
                        count_reg   <= count_reg + BYTES_PER_SAMPLE;
                        seen_reg    <= 1'b1;
                        if (conv.mag > peak_reg) begin
                            peak_reg <= conv.mag;
                        end
                    end else begin
                        out_pcm_reg <= '0;
                        out_wr_reg  <= 1'b0;
                        err_reg     <= 1'b1;
                    end
                end
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_pcm_sample     = out_pcm_reg;
    assign m_sample_written = out_wr_reg;
    assign m_peak_level     = peak_reg;
    assign m_peak_seen      = seen_reg;
    assign m_limit_error    = err_reg;
    assign m_bytes_total    = count_reg;
endmodule
`default_nettype wire
